// ===== rtl/core/swsg_pkg.sv =====
// ----------------------------------------------------------------------------
// swsg_pkg
// Shared types and constants of the scan wall segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package swsg_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GAP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_SCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_ERR   = 3'd4;

    localparam logic [15:0] RST_BASE_GAP   = 16'd100;
    localparam logic [15:0] RST_GAP_SCALE  = 16'd429;
    localparam logic [5:0]  RST_MIN_POINTS = 6'd5;
    localparam logic [15:0] RST_WALL_LEN   = 16'd350;
    localparam logic [15:0] RST_LINE_ERR   = 16'd50;

    localparam logic [11:0] WALL_MAX  = 12'd4095;
    localparam logic [11:0] WALL_INIT = 12'd1;

    // Sequential multiplier: 36 x 36 bits from four 18 x 18 partial products.
    localparam int MUL_HALF = 18;
    localparam int MUL_W    = 2 * MUL_HALF;
    localparam int PROD_W   = 2 * MUL_W;

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [15:0] base_gap_mm;
        logic [15:0] gap_scale;
        logic [5:0]  min_wall_points;
        logic [15:0] wall_length_mm;
        logic [15:0] line_error_mm;
    } t_cfg;

    // One classified point: brk closes the open segment before the point is added.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        brk;
        logic        eos;
    } t_cmd;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [11:0] label;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/core/swsg_if.sv =====
// ----------------------------------------------------------------------------
// swsg_if
// Valid/ready channels of the scan wall segmenter: points, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface swsg_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic        [15:0] point_range;
    logic               end_of_scan;
    modport source (output valid, point_x, point_y, point_range, end_of_scan, input ready);
    modport sink   (input valid, point_x, point_y, point_range, end_of_scan, output ready);
endinterface

interface swsg_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               is_wall;
    logic        [11:0] segment_label;
    logic               last_of_run;
    logic               scan_done;
    modport source (output valid, out_x, out_y, is_wall, segment_label, last_of_run,
                    scan_done, input ready);
    modport sink   (input valid, out_x, out_y, is_wall, segment_label, last_of_run,
                    scan_done, output ready);
endinterface

interface swsg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/scan_wall_segmenter.sv =====
// ----------------------------------------------------------------------------
// scan_wall_segmenter
// Splits a lidar scan into segments and flags the points of wall segments.
// ----------------------------------------------------------------------------
// The front stage takes one point at a time and runs the gap test, mostly in
// a 36 x 36 multiplier that builds one 18 x 18 partial product per cycle.
// Points go through a two-entry queue to the back stage, which stores a
// joining point. Closing a segment runs a setup, then a line check per point
// (again bound by the multiplier), then emits each point. Results leave
// through an output register; a stalled sink holds the back stage and,
// once the command queue is full, the front stage as well.
`default_nettype none

module scan_wall_segmenter #(
    parameter int MAX_SEGMENT_POINTS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    swsg_point_if.sink    i_point,
    swsg_result_if.source o_result,
    swsg_cfg_if.sink      i_cfg
);

    swsg_pkg::t_cfg r_cfg;
    swsg_pkg::t_cmd w_push_cmd;
    swsg_pkg::t_cmd w_pop_cmd;
    logic           w_push;
    logic           w_full;
    logic           w_qvalid;
    logic           w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_gap_mm     <= swsg_pkg::RST_BASE_GAP;
            r_cfg.gap_scale       <= swsg_pkg::RST_GAP_SCALE;
            r_cfg.min_wall_points <= swsg_pkg::RST_MIN_POINTS;
            r_cfg.wall_length_mm  <= swsg_pkg::RST_WALL_LEN;
            r_cfg.line_error_mm   <= swsg_pkg::RST_LINE_ERR;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                swsg_pkg::REG_BASE_GAP:   r_cfg.base_gap_mm     <= i_cfg.data;
                swsg_pkg::REG_GAP_SCALE:  r_cfg.gap_scale       <= i_cfg.data;
                swsg_pkg::REG_MIN_POINTS: r_cfg.min_wall_points <= i_cfg.data[5:0];
                swsg_pkg::REG_WALL_LEN:   r_cfg.wall_length_mm  <= i_cfg.data;
                swsg_pkg::REG_LINE_ERR:   r_cfg.line_error_mm   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    swsg_front #(.MAX_SEGMENT_POINTS(MAX_SEGMENT_POINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_point (i_point),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd),
        .i_full  (w_full)
    );

    swsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_data  (w_pop_cmd),
        .i_pop   (w_pop)
    );

    swsg_back #(.MAX_SEGMENT_POINTS(MAX_SEGMENT_POINTS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_qvalid),
        .i_q_cmd   (w_pop_cmd),
        .o_q_pop   (w_pop),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("command queue read while empty");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.scan_done) |-> o_result.last_of_run)
        else $error("scan end result not marked as last of its run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/swsg_mul.sv =====
// ----------------------------------------------------------------------------
// swsg_mul
// Unsigned 36 x 36 multiplier, one 18 x 18 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swsg_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [swsg_pkg::MUL_W-1:0]  i_a,
    input  wire logic [swsg_pkg::MUL_W-1:0]  i_b,
    output logic                             o_done,
    output logic      [swsg_pkg::PROD_W-1:0] o_prod
);

    localparam int H = swsg_pkg::MUL_HALF;

    logic [swsg_pkg::MUL_W-1:0]  r_a;
    logic [swsg_pkg::MUL_W-1:0]  r_b;
    logic [swsg_pkg::PROD_W-1:0] r_acc;
    logic [1:0]                  r_k;
    logic                        r_busy;
    logic                        r_done;

    logic [H-1:0]                w_ap;
    logic [H-1:0]                w_bp;
    logic [2*H-1:0]              w_pp;
    logic [1:0]                  w_sh;
    logic [swsg_pkg::PROD_W-1:0] w_term;

    assign w_ap = r_k[0] ? r_a[2*H-1:H] : r_a[H-1:0];
    assign w_bp = r_k[1] ? r_b[2*H-1:H] : r_b[H-1:0];
    assign w_pp = w_ap * w_bp;
    assign w_sh = {1'b0, r_k[0]} + {1'b0, r_k[1]};

    always_comb begin
        case (w_sh)
            2'd0:    w_term = {{(2*H){1'b0}}, w_pp};
            2'd1:    w_term = {{H{1'b0}}, w_pp, {H{1'b0}}};
            2'd2:    w_term = {w_pp, {(2*H){1'b0}}};
            default: w_term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ===== rtl/core/swsg_queue.sv =====
// ----------------------------------------------------------------------------
// swsg_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module swsg_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire swsg_pkg::t_cmd i_data,
    output logic                o_full,
    output logic                o_valid,
    output swsg_pkg::t_cmd      o_data,
    input  wire logic           i_pop
);

    localparam int AW = swsg_pkg::Q_AW;

    swsg_pkg::t_cmd r_buf [swsg_pkg::Q_DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_data;
    end

    assign o_full  = (r_cnt == (AW+1)'(swsg_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];

endmodule

`default_nettype wire

// ===== rtl/core/swsg_front.sv =====
// ----------------------------------------------------------------------------
// swsg_front
// Accepts points and decides whether each one joins the open segment.
// ----------------------------------------------------------------------------
`default_nettype none

module swsg_front #(
    parameter int MAX_SEGMENT_POINTS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire swsg_pkg::t_cfg i_cfg,
    swsg_point_if.sink          i_point,
    output logic                o_push,
    output swsg_pkg::t_cmd      o_cmd,
    input  wire logic           i_full
);

    localparam int CW = $clog2(MAX_SEGMENT_POINTS + 1);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_THR  = 6'b000010,
        F_GX   = 6'b000100,
        F_GY   = 6'b001000,
        F_WAIT = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    t_fstate             r_state;
    logic                r_open;
    logic [CW-1:0]       r_count;
    logic [15:0]         r_px;
    logic [15:0]         r_py;
    logic [15:0]         r_pr;
    logic [15:0]         r_x;
    logic [15:0]         r_y;
    logic [15:0]         r_r;
    logic                r_eos;
    logic                r_brk;
    logic signed [16:0]  r_dx;
    logic signed [16:0]  r_dy;
    logic [33:0]         r_t17;
    logic [33:0]         r_gsq;

    logic                        w_acc;
    logic [16:0]                 w_dx;
    logic [16:0]                 w_dy;
    logic [16:0]                 w_rsum;
    logic [32:0]                 w_scaled;
    logic signed [16:0]          w_sqin;
    logic signed [33:0]          w_sq;
    logic                        w_mdone;
    logic [swsg_pkg::PROD_W-1:0] w_prod;
    logic [swsg_pkg::PROD_W-1:0] w_lhs;

    assign w_acc    = i_point.valid && i_point.ready;
    assign w_dx     = {r_x[15], r_x} - {r_px[15], r_px};
    assign w_dy     = {r_y[15], r_y} - {r_py[15], r_py};
    assign w_rsum   = {1'b0, r_pr} + {1'b0, r_r};
    assign w_scaled = w_rsum * i_cfg.gap_scale;
    assign w_sqin   = (r_state == F_GX) ? r_dx : r_dy;
    assign w_sq     = w_sqin * w_sqin;
    // Compare gap squared against the Q.17 threshold squared, both scaled to 2^34.
    assign w_lhs    = {4'b0, r_gsq, 34'b0};

    swsg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == F_GX),
        .i_a     ({2'b0, r_t17}),
        .i_b     ({2'b0, r_t17}),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_open  <= 1'b0;
            r_count <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_pr    <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_acc) begin
                        if (!r_open || r_count >= CW'(MAX_SEGMENT_POINTS)) r_state <= F_PUSH;
                        else r_state <= F_THR;
                    end
                end
                F_THR:  r_state <= F_GX;
                F_GX:   r_state <= F_GY;
                F_GY:   r_state <= F_WAIT;
                F_WAIT: if (w_mdone) r_state <= F_PUSH;
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                        r_px    <= r_x;
                        r_py    <= r_y;
                        r_pr    <= r_r;
                        if (r_eos) begin
                            r_open  <= 1'b0;
                            r_count <= '0;
                        end else if (r_brk || !r_open) begin
                            r_open  <= 1'b1;
                            r_count <= CW'(1);
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (w_acc) begin
                    r_x   <= i_point.point_x;
                    r_y   <= i_point.point_y;
                    r_r   <= i_point.point_range;
                    r_eos <= i_point.end_of_scan;
                    r_brk <= r_open;
                end
            end
            F_THR: begin
                r_dx  <= $signed(w_dx);
                r_dy  <= $signed(w_dy);
                r_t17 <= {1'b0, i_cfg.base_gap_mm, 17'b0} + {1'b0, w_scaled};
            end
            F_GX:   r_gsq <= $unsigned(w_sq);
            F_GY:   r_gsq <= r_gsq + $unsigned(w_sq);
            F_WAIT: if (w_mdone) r_brk <= !(w_lhs < w_prod);
            default: ;
        endcase
    end

    assign i_point.ready = (r_state == F_IDLE);
    assign o_push        = (r_state == F_PUSH) && !i_full;
    assign o_cmd         = '{x: r_x, y: r_y, brk: r_brk, eos: r_eos};

endmodule

`default_nettype wire

// ===== rtl/core/swsg_back.sv =====
// ----------------------------------------------------------------------------
// swsg_back
// Holds the segment buffer, classifies closed segments and emits their points.
// ----------------------------------------------------------------------------
`default_nettype none

module swsg_back #(
    parameter int MAX_SEGMENT_POINTS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire swsg_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    input  wire swsg_pkg::t_cmd i_q_cmd,
    output logic                o_q_pop,
    swsg_result_if.source       o_result
);

    localparam int CW = $clog2(MAX_SEGMENT_POINTS + 1);
    localparam int AW = $clog2(MAX_SEGMENT_POINTS);

    typedef enum logic [18:0] {
        B_IDLE = 19'b0000000000000000001,
        B_APP  = 19'b0000000000000000010,
        B_C0   = 19'b0000000000000000100,
        B_C1   = 19'b0000000000000001000,
        B_C2   = 19'b0000000000000010000,
        B_C3   = 19'b0000000000000100000,
        B_C4   = 19'b0000000000001000000,
        B_C5   = 19'b0000000000010000000,
        B_C6   = 19'b0000000000100000000,
        B_P0   = 19'b0000000001000000000,
        B_P1   = 19'b0000000010000000000,
        B_P2   = 19'b0000000100000000000,
        B_P3   = 19'b0000001000000000000,
        B_P4   = 19'b0000010000000000000,
        B_PW   = 19'b0000100000000000000,
        B_E0   = 19'b0001000000000000000,
        B_E1   = 19'b0010000000000000000,
        B_E2   = 19'b0100000000000000000,
        B_FIN  = 19'b1000000000000000000
    } t_bstate;

    t_bstate          r_state;
    logic [CW-1:0]    r_cnt;
    logic [11:0]      r_wc;
    logic [AW-1:0]    r_idx;
    logic             r_flush;
    logic             r_wall;
    logic             r_ovalid;
    swsg_pkg::t_cmd   r_cmd;

    swsg_pkg::t_entry r_mem [MAX_SEGMENT_POINTS];
    swsg_pkg::t_entry r_rd;

    logic [15:0]        r_x1;
    logic [15:0]        r_y1;
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic signed [16:0] r_pdx;
    logic signed [16:0] r_pdy;
    logic signed [33:0] r_m1;
    logic [33:0]        r_cabs;
    logic [33:0]        r_len;
    logic [31:0]        r_lesq;
    logic [31:0]        r_wlsq;
    logic [swsg_pkg::PROD_W-1:0] r_th;

    logic [15:0]        r_ox;
    logic [15:0]        r_oy;
    logic               r_owall;
    logic [11:0]        r_olabel;
    logic               r_olast;
    logic               r_odone;

    logic [CW-1:0]               w_cm1;
    logic [AW-1:0]               w_last;
    logic [AW-1:0]               w_rd_addr;
    logic                        w_is_last;
    logic                        w_we;
    swsg_pkg::t_entry            w_wdata;
    logic [16:0]                 w_ex;
    logic [16:0]                 w_ey;
    logic signed [16:0]          w_sqin;
    logic signed [33:0]          w_sq;
    logic signed [33:0]          w_m2;
    logic [34:0]                 w_c;
    logic [34:0]                 w_cabs;
    logic                        w_few;
    logic                        w_long;
    logic                        w_mstart;
    logic [swsg_pkg::MUL_W-1:0]  w_ma;
    logic [swsg_pkg::MUL_W-1:0]  w_mb;
    logic                        w_mdone;
    logic [swsg_pkg::PROD_W-1:0] w_prod;
    logic                        w_load;

    assign w_cm1     = r_cnt - CW'(1);
    assign w_last    = w_cm1[AW-1:0];
    assign w_is_last = (r_idx == w_last);
    assign w_we      = (r_state == B_APP);
    assign w_wdata   = '{x: r_cmd.x, y: r_cmd.y, label: (r_cnt == '0) ? 12'd0 : r_wc};

    always_comb begin
        case (r_state)
            B_C0:    w_rd_addr = '0;
            B_C1:    w_rd_addr = w_last;
            default: w_rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_cnt[AW-1:0]] <= w_wdata;
        r_rd <= r_mem[w_rd_addr];
    end

    // Offsets of the entry just read from the segment's first point.
    assign w_ex   = {r_rd.x[15], r_rd.x} - {r_x1[15], r_x1};
    assign w_ey   = {r_rd.y[15], r_rd.y} - {r_y1[15], r_y1};
    assign w_sqin = (r_state == B_C3) ? r_dx : r_dy;
    assign w_sq   = w_sqin * w_sqin;
    assign w_m2   = r_dx * r_pdy;
    assign w_c    = {r_m1[33], r_m1} - {w_m2[33], w_m2};
    assign w_cabs = w_c[34] ? (~w_c + 35'd1) : w_c;

    assign w_few  = ({1'b0, i_cfg.min_wall_points} > 7'(r_cnt));
    assign w_long = (r_len > {2'b0, r_wlsq});

    assign w_mstart = (r_state == B_P3) || ((r_state == B_C5) && !w_long && (r_len != '0));
    assign w_ma     = (r_state == B_P3) ? {2'b0, r_cabs} : {4'b0, r_lesq};
    assign w_mb     = (r_state == B_P3) ? {2'b0, r_cabs} : {2'b0, r_len};

    swsg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    assign w_load  = (r_state == B_E2) && (!r_ovalid || o_result.ready);
    assign o_q_pop = (r_state == B_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cnt    <= '0;
            r_wc     <= swsg_pkg::WALL_INIT;
            r_idx    <= '0;
            r_flush  <= 1'b0;
            r_wall   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) r_ovalid <= 1'b1;
            else if (o_result.ready) r_ovalid <= 1'b0;

            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_flush <= 1'b0;
                        r_state <= i_q_cmd.brk ? B_C0 : B_APP;
                    end
                end
                B_APP: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cmd.eos) begin
                        r_flush <= 1'b1;
                        r_state <= B_C0;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_C0: begin
                    if (w_few) begin
                        r_wall  <= 1'b0;
                        r_state <= B_E0;
                    end else begin
                        r_state <= B_C1;
                    end
                end
                B_C1: r_state <= B_C2;
                B_C2: r_state <= B_C3;
                B_C3: r_state <= B_C4;
                B_C4: r_state <= B_C5;
                B_C5: begin
                    r_idx <= '0;
                    if (w_long) begin
                        r_wall  <= 1'b1;
                        r_state <= B_E0;
                    end else if (r_len == '0) begin
                        r_wall  <= 1'b0;
                        r_state <= B_E0;
                    end else begin
                        r_state <= B_C6;
                    end
                end
                B_C6: if (w_mdone) r_state <= B_P0;
                B_P0: r_state <= B_P1;
                B_P1: r_state <= B_P2;
                B_P2: r_state <= B_P3;
                B_P3: r_state <= B_P4;
                B_P4: begin
                    if (w_mdone) begin
                        if (!(w_prod < r_th)) begin
                            r_wall  <= 1'b0;
                            r_state <= B_E0;
                        end else if (w_is_last) begin
                            r_wall  <= 1'b1;
                            r_state <= B_E0;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= B_PW;
                        end
                    end
                end
                B_PW: r_state <= B_P0;
                B_E0: begin
                    r_idx   <= '0;
                    r_state <= B_E1;
                end
                B_E1: r_state <= B_E2;
                B_E2: begin
                    if (w_load) begin
                        if (w_is_last) begin
                            r_state <= B_FIN;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= B_E1;
                        end
                    end
                end
                B_FIN: begin
                    r_cnt <= '0;
                    if (r_flush) begin
                        r_wc    <= swsg_pkg::WALL_INIT;
                        r_state <= B_IDLE;
                    end else begin
                        if (r_wall && r_wc != swsg_pkg::WALL_MAX) r_wc <= r_wc + 12'd1;
                        r_state <= B_APP;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_cmd;
        case (r_state)
            B_C0: r_lesq <= i_cfg.line_error_mm * i_cfg.line_error_mm;
            B_C1: begin
                r_x1   <= r_rd.x;
                r_y1   <= r_rd.y;
                r_wlsq <= i_cfg.wall_length_mm * i_cfg.wall_length_mm;
            end
            B_C2: begin
                r_dx <= $signed(w_ex);
                r_dy <= $signed(w_ey);
            end
            B_C3: r_len <= $unsigned(w_sq);
            B_C4: r_len <= r_len + $unsigned(w_sq);
            B_C6: if (w_mdone) r_th <= w_prod;
            B_P0: begin
                r_pdx <= $signed(w_ex);
                r_pdy <= $signed(w_ey);
            end
            B_P1: r_m1   <= r_dy * r_pdx;
            B_P2: r_cabs <= w_cabs[33:0];
            default: ;
        endcase
        if (w_load) begin
            r_ox     <= r_rd.x;
            r_oy     <= r_rd.y;
            r_owall  <= r_wall;
            r_olabel <= r_rd.label;
            r_olast  <= w_is_last && (r_flush || !r_cmd.eos);
            r_odone  <= w_is_last && r_flush;
        end
    end

    assign o_result.valid         = r_ovalid;
    assign o_result.out_x         = r_ox;
    assign o_result.out_y         = r_oy;
    assign o_result.is_wall       = r_owall;
    assign o_result.segment_label = r_olabel;
    assign o_result.last_of_run   = r_olast;
    assign o_result.scan_done     = r_odone;

endmodule

`default_nettype wire

// ===== test/tb_scan_wall_segmenter.sv =====
// ----------------------------------------------------------------------------
// tb_scan_wall_segmenter
// Self-checking testbench of the scan wall segmenter. Lidar scans are
// streamed in, partly directed and mostly random walks along lines with
// jumps and noise. Each transfer updates a segment predictor, and every
// result is checked against the oldest predicted point.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scan_wall_segmenter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_DEPTH  = 32;
    localparam int STALL_LIM  = 5000;
    localparam int DRAIN_WAIT = 300;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               wall;
        logic        [11:0] label;
        logic               last;
        logic               done;
    } t_point_out;

    class seg_scoreboard;
        swsg_pkg::t_cfg     cfg;
        logic signed [15:0] buf_x[SEG_DEPTH];
        logic signed [15:0] buf_y[SEG_DEPTH];
        logic        [11:0] buf_label[SEG_DEPTH];
        int                 seg_len;
        logic signed [15:0] last_x, last_y;
        logic        [15:0] last_range;
        logic        [11:0] wall_cnt;
        logic               in_scan;
        t_point_out         pending[$];
        int                 errors;

        function new();
            cfg = '{swsg_pkg::RST_BASE_GAP, swsg_pkg::RST_GAP_SCALE,
                    swsg_pkg::RST_MIN_POINTS, swsg_pkg::RST_WALL_LEN,
                    swsg_pkg::RST_LINE_ERR};
            seg_len = 0;
            last_x = 0;
            last_y = 0;
            last_range = 0;
            wall_cnt = swsg_pkg::WALL_INIT;
            in_scan = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [swsg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                swsg_pkg::REG_BASE_GAP:   cfg.base_gap_mm = val;
                swsg_pkg::REG_GAP_SCALE:  cfg.gap_scale = val;
                swsg_pkg::REG_MIN_POINTS: cfg.min_wall_points = val[5:0];
                swsg_pkg::REG_WALL_LEN:   cfg.wall_length_mm = val;
                swsg_pkg::REG_LINE_ERR:   cfg.line_error_mm = val;
                default: ;
            endcase
        endfunction

        // Squared gap against the squared threshold, both scaled by 2^34.
        function logic close_enough(logic signed [15:0] x, logic signed [15:0] y,
                                    logic [15:0] r);
            longint dx, dy;
            logic [127:0] gap_sq, thr;
            dx = longint'(x) - longint'(last_x);
            dy = longint'(y) - longint'(last_y);
            gap_sq = 128'(dx * dx + dy * dy);
            thr = (128'(cfg.base_gap_mm) << 17)
                + (128'(last_range) + 128'(r)) * 128'(cfg.gap_scale);
            return (gap_sq << 34) < thr * thr;
        endfunction

        function logic seg_is_wall();
            longint dx, dy, len_sq, wl, c;
            logic [127:0] lim, c_sq;
            if (seg_len == 0 || seg_len < int'(cfg.min_wall_points)) return 0;
            dx = longint'(buf_x[seg_len-1]) - longint'(buf_x[0]);
            dy = longint'(buf_y[seg_len-1]) - longint'(buf_y[0]);
            len_sq = dx * dx + dy * dy;
            wl = longint'(cfg.wall_length_mm);
            if (len_sq > wl * wl) return 1;
            if (len_sq == 0) return 0;
            lim = 128'(cfg.line_error_mm) * 128'(cfg.line_error_mm) * 128'(len_sq);
            for (int i = 0; i < seg_len; i++) begin
                c = dy * (longint'(buf_x[i]) - longint'(buf_x[0]))
                  - dx * (longint'(buf_y[i]) - longint'(buf_y[0]));
                if (c < 0) c = -c;
                c_sq = 128'(c) * 128'(c);
                if (c_sq >= lim) return 0;
            end
            return 1;
        endfunction

        function void flush_segment(logic wall, logic done);
            t_point_out item;
            for (int i = 0; i < seg_len; i++) begin
                item = '{buf_x[i], buf_y[i], wall, buf_label[i], 1'b0,
                         done && (i == seg_len - 1)};
                pending.insert(pending.size(), item);
            end
            seg_len = 0;
        endfunction

        function void push_point(logic signed [15:0] x, logic signed [15:0] y,
                                 logic [11:0] label);
            buf_x[seg_len] = x;
            buf_y[seg_len] = y;
            buf_label[seg_len] = label;
            seg_len++;
        endfunction

        function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                                 logic [15:0] r, logic eos);
            int before_n;
            logic wall;
            before_n = pending.size();
            if (in_scan && seg_len > 0) begin
                if (seg_len < SEG_DEPTH && close_enough(x, y, r)) begin
                    push_point(x, y, wall_cnt);
                end else begin
                    wall = seg_is_wall();
                    flush_segment(wall, 1'b0);
                    if (wall && wall_cnt < swsg_pkg::WALL_MAX) wall_cnt++;
                    push_point(x, y, 12'd0);
                end
            end else begin
                seg_len = 0;
                push_point(x, y, 12'd0);
                in_scan = 1;
            end
            last_x = x;
            last_y = y;
            last_range = r;
            if (eos) begin
                wall = seg_is_wall();
                flush_segment(wall, 1'b1);
                in_scan = 0;
                wall_cnt = swsg_pkg::WALL_INIT;
            end
            if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check_result(t_point_out got);
            t_point_out want;
            if (pending.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", got.x, got.y);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $error("out_x: expected %0d, got %0d", want.x, got.x); errors++;
            end
            if (got.y !== want.y) begin
                $error("out_y: expected %0d, got %0d", want.y, got.y); errors++;
            end
            if (got.wall !== want.wall) begin
                $error("is_wall: expected %0d, got %0d", want.wall, got.wall); errors++;
            end
            if (got.label !== want.label) begin
                $error("segment_label: expected %0d, got %0d", want.label, got.label);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, got.last); errors++;
            end
            if (got.done !== want.done) begin
                $error("scan_done: expected %0d, got %0d", want.done, got.done); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    swsg_point_if  pt();
    swsg_result_if res();
    swsg_cfg_if    cfg_ch();

    scan_wall_segmenter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (pt.sink),
        .o_result(res.source),
        .i_cfg   (cfg_ch.sink)
    );

    seg_scoreboard sb = new();
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;
    int   stall_cycles = 0;

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end else begin
                res.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_result('{res.out_x, res.out_y, res.is_wall, res.segment_label,
                              res.last_of_run, res.scan_done});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pt.valid && pt.ready) || (res.valid && res.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIM) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                              logic [15:0] r, logic eos);
        pt.point_x = x;
        pt.point_y = y;
        pt.point_range = r;
        pt.end_of_scan = eos;
        pt.valid = 1'b1;
        do @(posedge i_clk); while (!pt.ready);
        sb.note_point(x, y, r, eos);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            pt.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [swsg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_ch.index = idx;
        cfg_ch.data = val;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Quiet point between scans: all results in, then time for the block to settle.
    task automatic drain();
        pt.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_config(logic [15:0] gap, logic [15:0] scale, logic [5:0] pts,
                              logic [15:0] wl, logic [15:0] le);
        drain();
        write_reg(swsg_pkg::REG_BASE_GAP, gap);
        write_reg(swsg_pkg::REG_GAP_SCALE, scale);
        write_reg(swsg_pkg::REG_MIN_POINTS, {10'd0, pts});
        write_reg(swsg_pkg::REG_WALL_LEN, wl);
        write_reg(swsg_pkg::REG_LINE_ERR, le);
    endtask

    // A scan walks along straight lines, with occasional jumps, noise and repeats.
    task automatic random_scan(int n_pts);
        logic signed [15:0] x, y, sx, sy;
        logic [15:0] r;
        int mode;
        x = 16'($urandom_range(0, 8000)) - 16'sd4000;
        y = 16'($urandom_range(0, 8000)) - 16'sd4000;
        sx = 16'($urandom_range(0, 80)) - 16'sd40;
        sy = 16'($urandom_range(0, 80)) - 16'sd40;
        for (int i = 0; i < n_pts; i++) begin
            mode = $urandom_range(0, 99);
            r = 16'($urandom_range(500, 8000));
            if (mode < 78) begin
                x = x + sx + 16'($urandom_range(0, 2)) - 16'sd1;
                y = y + sy;
            end else if (mode < 88) begin
                x = x + 16'($urandom_range(0, 4000)) - 16'sd2000;
                y = y + 16'($urandom_range(0, 4000)) - 16'sd2000;
                sx = 16'($urandom_range(0, 80)) - 16'sd40;
                sy = 16'($urandom_range(0, 80)) - 16'sd40;
            end else if (mode < 95) begin
                x = 16'($urandom);
                y = 16'($urandom);
                r = 16'($urandom);
            end
            send_point(x, y, r, i == n_pts - 1);
        end
    endtask

    task automatic random_phase(int n_items);
        int sent, n;
        sent = 0;
        while (sent < n_items) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 20);
            random_scan(n);
            sent += n;
        end
    endtask

    initial begin
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.point_range = '0;
        pt.end_of_scan = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed scans with the reset configuration.
        send_point(16'sd10, 16'sd20, 16'd1000, 1'b1);
        for (int i = 0; i < 6; i++)
            send_point(16'(i * 50), 16'sd500, 16'd2000, i == 5);
        for (int i = 0; i < 8; i++)
            send_point(16'sd300, 16'(i * 60), 16'd2000, 1'b0);
        send_point(-16'sd3000, 16'sd3000, 16'd4000, 1'b0);
        send_point(-16'sd3010, 16'sd3000, 16'd4000, 1'b1);
        send_point(-16'sd32768, 16'sd32767, 16'd65535, 1'b0);
        send_point(16'sd32767, -16'sd32768, 16'd0, 1'b1);
        for (int i = 0; i < 6; i++)
            send_point(16'sd77, -16'sd77, 16'd1500, i == 5);

        random_phase(70);

        set_config(16'd60, 16'd300, 6'd3, 16'd200, 16'd20);
        random_phase(30);
        hold_req = 1'b1;
        random_phase(50);

        set_config(16'd0, 16'd0, 6'd0, 16'd0, 16'd0);
        random_phase(60);

        set_config(16'd65535, 16'd65535, 6'd63, 16'd65535, 16'd65535);
        random_phase(70);

        set_config(16'd100, 16'd429, 6'd32, 16'd65535, 16'd65535);
        random_phase(70);

        set_config(16'($urandom_range(20, 200)), 16'($urandom_range(100, 2000)),
                   6'($urandom_range(1, 8)), 16'($urandom_range(100, 600)),
                   16'($urandom_range(5, 100)));
        idle_on = 1'b0;
        random_phase(70);

        pt.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
